/* src/most_and_least_repeated_value_macros.svh */
// assertion macros used by the checker file
`ifndef MOST_AND_LEAST_REPEATED_VALUE_MACROS_SVH
`define MOST_AND_LEAST_REPEATED_VALUE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MLR_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlr check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define MLR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlr check failed");

`endif

/* src/mlr_pkg.sv */
package mlr_pkg;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take_in;    // latch request payload, rewind entry pointer
        logic taken_inc;  // count the request toward the set size
        logic drop;       // set is full, mark the drop
        logic rd_en;      // read table entry at the pointer
        logic k_inc;      // advance entry pointer
        logic wr_inc;     // bump count of the matched entry
        logic wr_new;     // append request value as a new entry
        logic scan_init;  // rewind pointer, reset running best values
        logic acc_step;   // fold the entry just read into the best values
        logic out_load;   // load result register, clear the set
    } mlr_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic full;       // set already holds the maximum number of items
        logic used_zero;  // table is empty
        logic k_last;     // pointer is at the last used entry
        logic match;      // entry just read holds the request value
        logic last;       // latched request closes the set
        logic out_free;   // result register can take a new result
    } mlr_sts_t;

endpackage

/* src/most_and_least_repeated_value.sv */
// Most and least repeated value of a data set. Values arrive one request at a
// time on the in channel; the request with last high closes the set. The block
// keeps a table of distinct values in order of first appearance with their
// counts, in a single-port-read RAM of MAX_ITEMS words. On the closing request
// it sends one result: the most frequent value (earliest on ties) and the least
// frequent value among those seen at least twice (earliest on ties), each with
// its count and a found flag, plus overflow when requests beyond MAX_ITEMS in
// this set were dropped. The table is then emptied for the next set.
// Flow: one request at a time, taken only while the sequencer is idle. A
// request walks the table entry by entry through the one registered RAM read
// port, reading then comparing each entry, and appends a value not yet in the
// table; a dropped request skips the search. The closing request then reads
// and folds in every distinct value for the final scan and loads the result
// register. The next set may start while a result waits on out_ready; a new
// result waits only if the previous one was not yet taken.
module most_and_least_repeated_value
    import mlr_pkg::*;
#(
    parameter int MAX_ITEMS  = 64,   // set size and table depth, 2..1024
    parameter int VALUE_BITS = 8     // width of value, 1..32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [VALUE_BITS-1:0]          value,
    input  logic                           last,
    // result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [VALUE_BITS-1:0]          most_value,
    output logic [$clog2(MAX_ITEMS+1)-1:0] most_count,
    output logic                           most_found,
    output logic [VALUE_BITS-1:0]          least_value,
    output logic [$clog2(MAX_ITEMS+1)-1:0] least_count,
    output logic                           least_found,
    output logic                           overflow
);

    // command and status between sequencer and datapath
    mlr_cmd_t cmd;
    mlr_sts_t sts;

    // sequencer: search, append, final scan and result load
    mlr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: table RAM, set counters, running best values, result register
    mlr_dpath #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .value       (value),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .most_value  (most_value),
        .most_count  (most_count),
        .most_found  (most_found),
        .least_value (least_value),
        .least_count (least_count),
        .least_found (least_found),
        .overflow    (overflow)
    );

endmodule

/* src/mlr_ram.sv */
module mlr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/mlr_ctrl.sv */
module mlr_ctrl
    import mlr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  mlr_sts_t sts,
    output mlr_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CHECK    = 3'd1;
    localparam logic [2:0] ST_SRCH_RD  = 3'd2;
    localparam logic [2:0] ST_SRCH_CMP = 3'd3;
    localparam logic [2:0] ST_APPEND   = 3'd4;
    localparam logic [2:0] ST_SCAN_RD  = 3'd5;
    localparam logic [2:0] ST_SCAN_ACC = 3'd6;
    localparam logic [2:0] ST_EMIT     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.full)
                begin
                    cmd.drop = 1'b1;
                    if (sts.last)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_SCAN_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.taken_inc = 1'b1;
                    state_next    = sts.used_zero ? ST_APPEND : ST_SRCH_RD;
                end
            end
            ST_SRCH_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_SRCH_CMP;
            end
            ST_SRCH_CMP:
            begin
                if (sts.match)
                begin
                    cmd.wr_inc = 1'b1;
                    if (sts.last)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_SCAN_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (sts.k_last)
                begin
                    state_next = ST_APPEND;
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = ST_SRCH_RD;
                end
            end
            ST_APPEND:
            begin
                cmd.wr_new = 1'b1;
                if (sts.last)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_SCAN_ACC;
            end
            ST_SCAN_ACC:
            begin
                cmd.acc_step = 1'b1;
                if (sts.k_last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/mlr_dpath.sv */
module mlr_dpath
    import mlr_pkg::*;
#(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mlr_cmd_t                           cmd,
    output mlr_sts_t                           sts,
    input  logic [VALUE_BITS-1:0]              value,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [VALUE_BITS-1:0]              most_value,
    output logic [$clog2(MAX_ITEMS+1)-1:0]     most_count,
    output logic                               most_found,
    output logic [VALUE_BITS-1:0]              least_value,
    output logic [$clog2(MAX_ITEMS+1)-1:0]     least_count,
    output logic                               least_found,
    output logic                               overflow
);

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W  = $clog2(MAX_ITEMS);
    localparam int WORD_W = VALUE_BITS + CNT_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    // request latch and table bookkeeping
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  last_reg, last_next;
    logic [IDX_W-1:0]      k_reg, k_next;
    logic [CNT_W-1:0]      used_reg, used_next;
    logic [CNT_W-1:0]      taken_reg, taken_next;
    logic                  dropped_reg, dropped_next;

    // running best values of the final scan
    logic [VALUE_BITS-1:0] most_v_reg, most_v_next;
    logic [CNT_W-1:0]      most_c_reg, most_c_next;
    logic [VALUE_BITS-1:0] least_v_reg, least_v_next;
    logic [CNT_W-1:0]      least_c_reg, least_c_next;
    logic                  least_ok_reg, least_ok_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] o_most_v_reg, o_most_v_next;
    logic [CNT_W-1:0]      o_most_c_reg, o_most_c_next;
    logic [VALUE_BITS-1:0] o_least_v_reg, o_least_v_next;
    logic [CNT_W-1:0]      o_least_c_reg, o_least_c_next;
    logic                  o_least_ok_reg, o_least_ok_next;
    logic                  o_ovf_reg, o_ovf_next;

    // table memory, one word per distinct value: {value, count}
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [WORD_W-1:0] rd_data;
    logic [VALUE_BITS-1:0] rd_val;
    logic [CNT_W-1:0]      rd_cnt;

    assign rd_val = rd_data[WORD_W-1:CNT_W];
    assign rd_cnt = rd_data[CNT_W-1:0];

    assign wr_en   = cmd.wr_inc | cmd.wr_new;
    assign wr_addr = cmd.wr_new ? used_reg[IDX_W-1:0] : k_reg;
    assign wr_data = cmd.wr_new ? {value_reg, ONE_CNT} : {value_reg, rd_cnt + ONE_CNT};

    mlr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ITEMS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (k_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        sts.full      = (taken_reg == MAX_CNT);
        sts.used_zero = (used_reg == '0);
        sts.k_last    = (CNT_W'(k_reg) == used_reg - ONE_CNT);
        sts.match     = (rd_val == value_reg);
        sts.last      = last_reg;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        value_next   = cmd.take_in ? value : value_reg;
        last_next    = cmd.take_in ? last : last_reg;
        k_next       = k_reg;
        used_next    = used_reg;
        taken_next   = taken_reg;
        dropped_next = dropped_reg;

        if (cmd.take_in || cmd.scan_init)
        begin
            k_next = '0;
        end
        else if (cmd.k_inc)
        begin
            k_next = k_reg + IDX_W'(1);
        end

        if (cmd.taken_inc)
        begin
            taken_next = taken_reg + ONE_CNT;
        end
        if (cmd.wr_new)
        begin
            used_next = used_reg + ONE_CNT;
        end
        if (cmd.drop)
        begin
            dropped_next = 1'b1;
        end
        // result is out, start a fresh set
        if (cmd.out_load)
        begin
            used_next    = '0;
            taken_next   = '0;
            dropped_next = 1'b0;
        end
    end

    always_comb
    begin
        most_v_next   = most_v_reg;
        most_c_next   = most_c_reg;
        least_v_next  = least_v_reg;
        least_c_next  = least_c_reg;
        least_ok_next = least_ok_reg;
        if (cmd.scan_init)
        begin
            most_v_next   = '0;
            most_c_next   = '0;
            least_v_next  = '0;
            least_c_next  = '0;
            least_ok_next = 1'b0;
        end
        else if (cmd.acc_step)
        begin
            // strict compares keep the earliest entry on ties
            if (rd_cnt > most_c_reg)
            begin
                most_v_next = rd_val;
                most_c_next = rd_cnt;
            end
            if ((rd_cnt > ONE_CNT) && (!least_ok_reg || (rd_cnt < least_c_reg)))
            begin
                least_v_next  = rd_val;
                least_c_next  = rd_cnt;
                least_ok_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        o_most_v_next   = o_most_v_reg;
        o_most_c_next   = o_most_c_reg;
        o_least_v_next  = o_least_v_reg;
        o_least_c_next  = o_least_c_reg;
        o_least_ok_next = o_least_ok_reg;
        o_ovf_next      = o_ovf_reg;
        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            o_most_v_next   = most_v_reg;
            o_most_c_next   = most_c_reg;
            o_least_v_next  = least_v_reg;
            o_least_c_next  = least_c_reg;
            o_least_ok_next = least_ok_reg;
            o_ovf_next      = dropped_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            taken_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            least_ok_reg  <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            taken_reg     <= taken_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            least_ok_reg  <= least_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        last_reg       <= last_next;
        most_v_reg     <= most_v_next;
        most_c_reg     <= most_c_next;
        least_v_reg    <= least_v_next;
        least_c_reg    <= least_c_next;
        o_most_v_reg   <= o_most_v_next;
        o_most_c_reg   <= o_most_c_next;
        o_least_v_reg  <= o_least_v_next;
        o_least_c_reg  <= o_least_c_next;
        o_least_ok_reg <= o_least_ok_next;
        o_ovf_reg      <= o_ovf_next;
    end

    assign out_valid   = out_valid_reg;
    assign most_value  = o_most_v_reg;
    assign most_count  = o_most_c_reg;
    assign most_found  = (o_most_c_reg > ONE_CNT);
    assign least_value = o_least_v_reg;
    assign least_count = o_least_c_reg;
    assign least_found = o_least_ok_reg;
    assign overflow    = o_ovf_reg;

endmodule

/* src/mlr_checker.sv */
`include "most_and_least_repeated_value_macros.svh"

module mlr_checker #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 8
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [VALUE_BITS-1:0]          most_value,
    input logic [$clog2(MAX_ITEMS+1)-1:0] most_count,
    input logic                           most_found,
    input logic [$clog2(MAX_ITEMS+1)-1:0] least_count,
    input logic                           least_found
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    // stalled result holds
    `MLR_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(most_value) && $stable(most_count))

    // most count is between one and the set size, found iff above one
    `MLR_ASSERT_NOW(a_most_range, out_valid, most_count != '0 && most_count <= MAX_CNT && most_found == (most_count > ONE_CNT))

    // least count is zero when nothing repeats, else at least two
    `MLR_ASSERT_NOW(a_least_found, out_valid, least_found ? (least_count > ONE_CNT) : (least_count == '0))

    // least frequent repeated value never beats the most frequent
    `MLR_ASSERT_NOW(a_least_le_most, out_valid && least_found, least_count <= most_count && most_found)

endmodule

bind most_and_least_repeated_value mlr_checker #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
) u_mlr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .most_value  (most_value),
    .most_count  (most_count),
    .most_found  (most_found),
    .least_count (least_count),
    .least_found (least_found)
);
